// File: src/ffra_pkg.sv
// shared constants for the first-fit range allocator
`default_nettype none
package ffra_pkg;

  localparam int FreeSlotsDef = 64;
  localparam int ClientsDef   = 16;
  localparam int AddrBitsDef  = 8;

  localparam int IdSlots    = 16;
  localparam int InWordW    = 16;
  localparam int OutWordW   = 24;
  localparam int CfgAddrW   = 3;

  localparam logic [7:0] PoolSizeRst   = 8'd100;
  localparam logic [7:0] MaxRequestRst = 8'd25;

  localparam logic [0:0] RegPoolSize   = 1'b0;
  localparam logic [0:0] RegMaxRequest = 1'b1;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_FREE    = 2'd1,
    KIND_KILL    = 2'd2,
    KIND_INSPECT = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_OVER_LIMIT = 3'd1,
    ST_HOLDS      = 3'd2,
    ST_SHORT      = 3'd3,
    ST_NO_FIT     = 3'd4,
    ST_UNKNOWN    = 3'd5,
    ST_NOTHING    = 3'd6,
    ST_TABLE_FULL = 3'd7
  } status_e;

endpackage
`default_nettype wire

// File: src/ffra_slot_mem.sv
// free-range table storage, one write and one registered read port
`default_nettype none
module ffra_slot_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 16
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [DW-1:0] wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output      logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

// File: src/first_fit_range_allocator_core.sv
// First-fit range allocator over units 1..pool_size with one range per client.
// Allocate walks the whole free table, one slot per cycle through the table
// memory's read port; free and kill look for the lowest empty slot, one slot
// per cycle; inspect and requests that are turned away at once go straight to
// the finish state. Writing pool_size rebuilds the pool. The result word sits
// in an output register, so a new word is taken while the last result waits.
`default_nettype none
module first_fit_range_allocator_core
  import ffra_pkg::*;
#(
  parameter int FREE_SLOTS = FreeSlotsDef,
  parameter int CLIENTS    = ClientsDef,
  parameter int ADDR_BITS  = AddrBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output      logic                  s_axis_tready,
  // kind, client_id, request_size
  input  wire logic [InWordW-1:0]    s_axis_tdata,
  output      logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // status, has_range, range_first, range_last
  output      logic [OutWordW-1:0]   m_axis_tdata,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CfgAddrW-1:0]   paddr,
  input  wire logic [31:0]           pwdata,
  output      logic [31:0]           prdata,
  output      logic                  pready
);

  localparam int SW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
  localparam int CW = $clog2(FREE_SLOTS + 1);
  localparam int AB = ADDR_BITS;
  localparam int LW = (AB + 1 > 9) ? AB + 1 : 9;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_AUPD = 3'd2;
  localparam logic [2:0] S_REL  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [7:0]  pool_q, maxreq_q;
  logic [7:0]  units_q, units_d;
  logic [FREE_SLOTS-1:0] fvalid_q, fvalid_d;
  logic        ovr_q, ovr_d;
  logic [IdSlots-1:0] known_q, known_d;
  logic [AB-1:0] cfirst_q [IdSlots];
  logic [AB-1:0] clast_q  [IdSlots];
  logic [AB-1:0] cfirst_d [IdSlots];
  logic [AB-1:0] clast_d  [IdSlots];

  logic [1:0]  kind_q, kind_d;
  logic [3:0]  cid_q, cid_d;
  logic [7:0]  size_q, size_d;
  logic [2:0]  status_q, status_d;

  logic [CW-1:0] cnt_q, cnt_d;
  logic        pend_q, pend_d;
  logic [SW-1:0] ridx_q;
  logic        rvalid_q, rovr_q;
  logic        found_q, found_d;
  logic [SW-1:0] bidx_q, bidx_d;
  logic [AB-1:0] bstart_q, bstart_d, bend_q, bend_d;

  logic        mvalid_q, mvalid_d;
  logic [OutWordW-1:0] mdata_q, mdata_d;

  logic        wr_en, rd_en;
  logic [SW-1:0] wr_addr, rd_addr;
  logic [2*AB-1:0] wr_data, rd_data;

  logic        acc, cfg_wr;
  logic [1:0]  in_kind;
  logic [3:0]  in_cid;
  logic [7:0]  in_size;
  logic        in_range, cur_range;
  logic [3:0]  in_c, cur_c;
  logic [AB-1:0] sc_start, sc_end;
  logic [LW-1:0] sc_len, b_len;
  logic        cand;
  logic [AB-1:0] rel_len;
  logic        holds;

  ffra_slot_mem #(.DEPTH(FREE_SLOTS), .AW(SW), .DW(2 * AB)) u_slots (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign pready        = 1'b1;
  assign cfg_wr        = psel & penable & pwrite;
  assign prdata        = (paddr[2] == RegPoolSize) ? {24'd0, pool_q} : {24'd0, maxreq_q};
  assign s_axis_tready = (state_q == S_IDLE);
  assign acc           = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = mdata_q;

  assign in_kind   = s_axis_tdata[1:0];
  assign in_cid    = s_axis_tdata[5:2];
  assign in_size   = s_axis_tdata[13:6];
  assign in_range  = (32'(in_cid) < 32'(CLIENTS));
  assign in_c      = in_range ? in_cid : 4'd0;
  assign cur_range = (32'(cid_q) < 32'(CLIENTS));
  assign cur_c     = cur_range ? cid_q : 4'd0;

  assign rd_addr  = cnt_q[SW-1:0];
  assign sc_start = rovr_q ? AB'(1) : rd_data[2*AB-1:AB];
  assign sc_end   = rovr_q ? AB'(pool_q) : rd_data[AB-1:0];
  assign sc_len   = LW'(sc_end) - LW'(sc_start) + LW'(1);
  assign cand     = rvalid_q && (sc_end >= sc_start) && (sc_len >= LW'(size_q)) &&
                    (!found_q || sc_start < bstart_q);
  assign b_len    = LW'(bend_q) - LW'(bstart_q) + LW'(1);
  assign rel_len  = clast_q[cur_c] - cfirst_q[cur_c] + AB'(1);
  assign holds    = cur_range && known_q[cur_c] && (cfirst_q[cur_c] != '0);

  always_comb begin
    state_d  = state_q;
    units_d  = units_q;
    fvalid_d = fvalid_q;
    ovr_d    = ovr_q;
    known_d  = known_q;
    cfirst_d = cfirst_q;
    clast_d  = clast_q;
    kind_d   = kind_q;
    cid_d    = cid_q;
    size_d   = size_q;
    status_d = status_q;
    cnt_d    = cnt_q;
    pend_d   = 1'b0;
    found_d  = found_q;
    bidx_d   = bidx_q;
    bstart_d = bstart_q;
    bend_d   = bend_q;
    mvalid_d = mvalid_q;
    mdata_d  = mdata_q;
    wr_en    = 1'b0;
    wr_addr  = bidx_q;
    wr_data  = {bstart_q + AB'(size_q), bend_q};
    rd_en    = 1'b0;

    if (mvalid_q && m_axis_tready) begin
      mvalid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (acc) begin
          kind_d  = in_kind;
          cid_d   = in_cid;
          size_d  = in_size;
          cnt_d   = '0;
          found_d = 1'b0;
          state_d = S_FIN;
          if (in_kind == KIND_ALLOC) begin
            if (in_size == 8'd0 || in_size > maxreq_q) begin
              status_d = ST_OVER_LIMIT;
            end else if (!in_range) begin
              status_d = ST_UNKNOWN;
            end else begin
              known_d[in_c] = 1'b1;
              if (cfirst_q[in_c] != '0) begin
                status_d = ST_HOLDS;
              end else if (units_q < in_size) begin
                status_d = ST_SHORT;
              end else begin
                state_d = S_SCAN;
              end
            end
          end else if (!in_range || !known_q[in_c]) begin
            status_d = ST_UNKNOWN;
          end else if (in_kind == KIND_INSPECT) begin
            status_d = ST_OK;
          end else if (cfirst_q[in_c] == '0) begin
            status_d = ST_NOTHING;
            if (in_kind == KIND_KILL) begin
              known_d[in_c] = 1'b0;
            end
          end else begin
            state_d = S_REL;
          end
        end
      end
      S_SCAN: begin
        if (cnt_q < CW'(FREE_SLOTS)) begin
          rd_en  = 1'b1;
          pend_d = 1'b1;
          cnt_d  = cnt_q + CW'(1);
        end
        if (pend_q && cand) begin
          found_d  = 1'b1;
          bidx_d   = ridx_q;
          bstart_d = sc_start;
          bend_d   = sc_end;
        end
        if (cnt_q == CW'(FREE_SLOTS) && !pend_q) begin
          state_d = S_AUPD;
        end
      end
      S_AUPD: begin
        state_d = S_FIN;
        if (!found_q) begin
          status_d = ST_NO_FIT;
        end else begin
          status_d        = ST_OK;
          cfirst_d[cur_c] = bstart_q;
          clast_d[cur_c]  = bstart_q + AB'(size_q) - AB'(1);
          units_d         = units_q - size_q;
          if (bidx_q == '0) begin
            ovr_d = 1'b0;
          end
          if (b_len > LW'(size_q)) begin
            wr_en = 1'b1;
          end else begin
            fvalid_d[bidx_q] = 1'b0;
          end
        end
      end
      S_REL: begin
        if (cnt_q == CW'(FREE_SLOTS)) begin
          status_d = ST_TABLE_FULL;
          state_d  = S_FIN;
        end else if (!fvalid_q[cnt_q[SW-1:0]]) begin
          wr_en   = 1'b1;
          wr_addr = cnt_q[SW-1:0];
          wr_data = {cfirst_q[cur_c], clast_q[cur_c]};
          fvalid_d[cnt_q[SW-1:0]] = 1'b1;
          if (cnt_q == '0) begin
            ovr_d = 1'b0;
          end
          units_d         = units_q + 8'(rel_len);
          cfirst_d[cur_c] = '0;
          clast_d[cur_c]  = '0;
          if (kind_q == KIND_KILL) begin
            known_d[cur_c] = 1'b0;
          end
          status_d = ST_OK;
          state_d  = S_FIN;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      S_FIN: begin
        if (!mvalid_q || m_axis_tready) begin
          mvalid_d = 1'b1;
          mdata_d  = {4'd0, holds ? 8'(clast_q[cur_c]) : 8'd0,
                      holds ? 8'(cfirst_q[cur_c]) : 8'd0, holds, status_q};
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // pool rebuild
    if (cfg_wr && paddr[2] == RegPoolSize) begin
      units_d  = pwdata[7:0];
      fvalid_d = FREE_SLOTS'(pwdata[7:0] != 8'd0);
      ovr_d    = 1'b1;
      known_d  = '0;
      for (int i = 0; i < IdSlots; i++) begin
        cfirst_d[i] = '0;
        clast_d[i]  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q   <= PoolSizeRst;
      maxreq_q <= MaxRequestRst;
    end else if (cfg_wr) begin
      if (paddr[2] == RegPoolSize) begin
        pool_q <= pwdata[7:0];
      end else begin
        maxreq_q <= pwdata[7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      units_q  <= PoolSizeRst;
      fvalid_q <= FREE_SLOTS'(1);
      ovr_q    <= 1'b1;
      known_q  <= '0;
      for (int i = 0; i < IdSlots; i++) begin
        cfirst_q[i] <= '0;
        clast_q[i]  <= '0;
      end
      cnt_q    <= '0;
      pend_q   <= 1'b0;
      found_q  <= 1'b0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      units_q  <= units_d;
      fvalid_q <= fvalid_d;
      ovr_q    <= ovr_d;
      known_q  <= known_d;
      cfirst_q <= cfirst_d;
      clast_q  <= clast_d;
      cnt_q    <= cnt_d;
      pend_q   <= pend_d;
      found_q  <= found_d;
      mvalid_q <= mvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    cid_q    <= cid_d;
    size_q   <= size_d;
    status_q <= status_d;
    bidx_q   <= bidx_d;
    bstart_q <= bstart_d;
    bend_q   <= bend_d;
    mdata_q  <= mdata_d;
    ridx_q   <= rd_addr;
    rvalid_q <= fvalid_q[rd_addr];
    rovr_q   <= ovr_q && (rd_addr == '0);
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(FREE_SLOTS))
    else $error("scan counter past table end");

  a_best_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AUPD && found_q) |-> fvalid_q[bidx_q])
    else $error("chosen slot is not valid");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(mvalid_q) |-> $past(state_q == S_FIN))
    else $error("result word raised outside finish");

  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_REL) |=> !acc || $past(state_q == S_FIN)
      || state_q == S_IDLE)
    else $error("word taken while busy");

endmodule
`default_nettype wire

// File: tb/sv/tb_first_fit_range_allocator_core.sv
// self-checking testbench for the first-fit range allocator core
`timescale 1ns / 100ps
module tb_first_fit_range_allocator_core;
  import ffra_pkg::*;

  localparam int NSLOT = FreeSlotsDef;
  localparam int NCLI  = ClientsDef;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // kind [1:0], client_id [5:2], request_size [13:6], zero fill
  logic [InWordW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // status [2:0], has_range [3], range_first [11:4], range_last [19:12], zero fill
  logic [OutWordW-1:0] m_axis_tdata;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  first_fit_range_allocator_core uut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  typedef struct packed {
    logic [7:0] last;
    logic [7:0] first;
    logic       has_range;
    status_e    status;
  } answer_t;

  // allocator shadow
  logic [7:0] pool_units, size_limit, units_left;
  logic       slot_used [NSLOT];
  logic [7:0] slot_lo [NSLOT];
  logic [7:0] slot_hi [NSLOT];
  logic       cli_known [NCLI];
  logic [7:0] cli_lo [NCLI];
  logic [7:0] cli_hi [NCLI];

  answer_t answers_due [$];
  int      errors = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_cycles = 0;

  task automatic reset_pool();
    units_left = pool_units;
    for (int s = 0; s < NSLOT; s++) begin
      slot_used[s] = 1'b0; slot_lo[s] = '0; slot_hi[s] = '0;
    end
    for (int c = 0; c < NCLI; c++) begin
      cli_known[c] = 1'b0; cli_lo[c] = '0; cli_hi[c] = '0;
    end
    if (pool_units != 0) begin
      slot_used[0] = 1'b1; slot_lo[0] = 8'd1; slot_hi[0] = pool_units;
    end
  endtask

  function automatic status_e give_back(int c);
    int s;
    if (cli_lo[c] == 0) return ST_NOTHING;
    for (s = 0; s < NSLOT; s++) if (!slot_used[s]) break;
    if (s >= NSLOT) return ST_TABLE_FULL;
    slot_used[s] = 1'b1; slot_lo[s] = cli_lo[c]; slot_hi[s] = cli_hi[c];
    units_left = units_left + 8'(cli_hi[c] - cli_lo[c] + 8'd1);
    cli_lo[c] = '0; cli_hi[c] = '0;
    return ST_OK;
  endfunction

  function automatic status_e take_range(int c, logic [7:0] size);
    int pick;
    pick = NSLOT;
    if (size == 0 || size > size_limit) return ST_OVER_LIMIT;
    cli_known[c] = 1'b1;
    if (cli_lo[c] != 0) return ST_HOLDS;
    if (units_left < size) return ST_SHORT;
    for (int s = 0; s < NSLOT; s++) begin
      if (!slot_used[s] || slot_hi[s] < slot_lo[s]) continue;
      if (int'(slot_hi[s]) - int'(slot_lo[s]) + 1 < int'(size)) continue;
      if (pick == NSLOT || slot_lo[s] < slot_lo[pick]) pick = s;
    end
    if (pick == NSLOT) return ST_NO_FIT;
    cli_lo[c] = slot_lo[pick];
    cli_hi[c] = slot_lo[pick] + size - 8'd1;
    if (int'(slot_hi[pick]) - int'(slot_lo[pick]) + 1 > int'(size))
      slot_lo[pick] = slot_lo[pick] + size;
    else
      slot_used[pick] = 1'b0;
    units_left = units_left - size;
    return ST_OK;
  endfunction

  function automatic answer_t predict_answer(kind_e k, int c, logic [7:0] size);
    answer_t a;
    a = '0;
    if (k == KIND_ALLOC) a.status = take_range(c, size);
    else if (!cli_known[c]) a.status = ST_UNKNOWN;
    else if (k == KIND_FREE) a.status = give_back(c);
    else if (k == KIND_KILL) begin
      a.status = give_back(c);
      if (a.status == ST_OK || a.status == ST_NOTHING) begin
        cli_known[c] = 1'b0; cli_lo[c] = '0; cli_hi[c] = '0;
      end
    end else a.status = ST_OK;
    if (cli_known[c] && cli_lo[c] != 0) begin
      a.has_range = 1'b1; a.first = cli_lo[c]; a.last = cli_hi[c];
    end
    return a;
  endfunction

  task automatic send_request(kind_e k, int c, int size);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, size[7:0], c[3:0], k};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    answers_due.push_back(predict_answer(k, c, size[7:0]));
  endtask

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else
      m_axis_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    answer_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = answer_t'(m_axis_tdata[19:0]);
      if (answers_due.size() == 0) begin
        errors++;
        $display("%0t unexpected word: expected none, got %h", $time, got);
      end else begin
        want = answers_due.pop_front();
        if (got.status !== want.status || got.has_range !== want.has_range ||
            got.first !== want.first || got.last !== want.last) begin
          errors++;
          $display("%0t mismatch: expected st=%0d h=%0d %0d..%0d, got st=%0d h=%0d %0d..%0d",
                   $time, want.status, want.has_range, want.first, want.last,
                   got.status, got.has_range, got.first, got.last);
        end
      end
    end
  end

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (NSLOT + 8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [7:0] val);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= CfgAddrW'(4 * idx); pwdata <= {24'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == RegPoolSize) begin
      pool_units = val;
      reset_pool();
    end else
      size_limit = val;
    @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_request(KIND_INSPECT, 3, 0);
    send_request(KIND_FREE, 3, 0);
    send_request(KIND_KILL, 15, 255);
    send_request(KIND_ALLOC, 0, 0);
    send_request(KIND_ALLOC, 0, 26);
    send_request(KIND_ALLOC, 0, 255);
    send_request(KIND_ALLOC, 0, 25);
    send_request(KIND_ALLOC, 0, 5);
    send_request(KIND_ALLOC, 15, 1);
    send_request(KIND_INSPECT, 0, 0);
    send_request(KIND_FREE, 0, 0);
    send_request(KIND_FREE, 0, 0);
    send_request(KIND_KILL, 0, 0);
    send_request(KIND_INSPECT, 0, 0);
    send_request(KIND_ALLOC, 1, 25);
    send_request(KIND_ALLOC, 2, 25);
    send_request(KIND_ALLOC, 4, 25);
    send_request(KIND_ALLOC, 5, 24);
    send_request(KIND_ALLOC, 6, 2);
    send_request(KIND_KILL, 1, 0);
    send_request(KIND_ALLOC, 7, 25);
    send_request(KIND_KILL, 15, 170);
    drain();
  endtask

  task automatic test_table_full();
    write_reg(RegPoolSize, 8'd255);
    write_reg(RegMaxRequest, 8'd4);
    for (int r = 1; r <= 4; r++) begin
      for (int c = 0; c < NCLI; c++) send_request(KIND_ALLOC, c, r);
      for (int c = 0; c < NCLI; c++) send_request(KIND_FREE, c, 0);
    end
    drain();
    write_reg(RegPoolSize, 8'd0);
    send_request(KIND_ALLOC, 2, 1);
    drain();
    write_reg(RegMaxRequest, 8'd0);
    send_request(KIND_ALLOC, 2, 1);
    drain();
  endtask

  task automatic test_random(int n, int pool, int lim, int idle, int stall);
    int c, r;
    kind_e k;
    write_reg(RegPoolSize, pool[7:0]);
    write_reg(RegMaxRequest, lim[7:0]);
    send_idle_pct = idle; recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(NCLI - 1);
      r = $urandom_range(99);
      k = r < 45 ? KIND_ALLOC : r < 65 ? KIND_FREE : r < 82 ? KIND_KILL : KIND_INSPECT;
      send_request(k, c, $urandom_range(9) == 0 ? $urandom_range(255)
                                                : $urandom_range(lim < 1 ? 1 : lim));
    end
    drain();
    send_idle_pct = 0; recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 30; i++) send_request(KIND_INSPECT, $urandom_range(NCLI - 1), 0);
    drain();
  endtask

  initial begin
    pool_units = PoolSizeRst; size_limit = MaxRequestRst;
    reset_pool();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_table_full();
    test_random(300, 100, 25, 0, 0);
    test_random(300, 60, 20, 54, 0);
    test_random(300, 255, 255, 0, 54);
    test_random(300, 1, 1, 21, 21);
    test_random(70, 200, 40, 0, 0);
    test_backpressure();
    if (errors == 0) $display("PASS first_fit_range_allocator_core");
    else $display("FAIL first_fit_range_allocator_core");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL first_fit_range_allocator_core");
    $finish;
  end

endmodule

// File: first_fit_range_allocator_core.f
src/ffra_pkg.sv
src/ffra_slot_mem.sv
src/first_fit_range_allocator_core.sv
tb/sv/tb_first_fit_range_allocator_core.sv
